// ----- hdl/bleuuid_pkg.sv -----
// Shared types, constants and helpers for the BLE advertising UUID16 matcher.
`timescale 1ns / 1ps

package bleuuid_pkg;

    localparam int UUID_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int NUM_TGT  = 3;
    localparam int REG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] AD_TYPE_UUID16_MORE     = 8'h02;
    localparam logic [BYTE_W-1:0] AD_TYPE_UUID16_COMPLETE = 8'h03;

    localparam logic [UUID_W-1:0] TARGET_A_RESET = 16'h1814;
    localparam logic [UUID_W-1:0] TARGET_B_RESET = 16'h180D;
    localparam logic [UUID_W-1:0] TARGET_C_RESET = 16'h1816;

    // Register indexes on the configuration channel
    typedef enum logic [REG_IDX_W-1:0] {
        REG_TARGET_A = 2'd0,
        REG_TARGET_B = 2'd1,
        REG_TARGET_C = 2'd2
    } reg_index_t;

    // Which UUID list is used; also the kind of the structure being parsed
    typedef enum logic [1:0] {
        SRC_NONE     = 2'd0,
        SRC_MORE     = 2'd1,
        SRC_COMPLETE = 2'd2
    } list_src_t;

    typedef struct packed {
        logic [UUID_W-1:0] a;
        logic [UUID_W-1:0] b;
        logic [UUID_W-1:0] c;
    } target_set_t;

    // Report summary after the current byte
    typedef struct packed {
        logic [NUM_TGT-1:0] match;
        list_src_t          src;
    } report_sum_t;

    function automatic logic [NUM_TGT-1:0] compare_targets(
        input logic [UUID_W-1:0] u,
        input target_set_t       t
    );
        logic [NUM_TGT-1:0] m;
        m[0] = (u == t.a);
        m[1] = (u == t.b);
        m[2] = (u == t.c);
        return m;
    endfunction

endpackage

// ----- hdl/bleuuid_if.sv -----
// Valid/ready channel interfaces: report bytes, results and register writes.
`timescale 1ns / 1ps

interface bleuuid_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [2:0] search_mask;

    modport source (output valid, data_byte, last_byte, search_mask, input ready);
    modport sink   (input valid, data_byte, last_byte, search_mask, output ready);
endinterface

interface bleuuid_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] report_match;
    logic [1:0] list_source;
    logic [2:0] found_mask;
    logic [2:0] connect_mask;

    modport source (output valid, report_match, list_source, found_mask, connect_mask,
                    input ready);
    modport sink   (input valid, report_match, list_source, found_mask, connect_mask,
                    output ready);
endinterface

interface bleuuid_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [15:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- hdl/bleuuid_parser.sv -----
// Length/type/data walker that collects UUID16 list matches for one report.
`timescale 1ns / 1ps

module bleuuid_parser #(
    parameter int MAX_REPORT_BYTES = 31
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [7:0]                   data_byte,
    input  logic                         last_byte,
    input  bleuuid_pkg::target_set_t     targets,
    output bleuuid_pkg::report_sum_t     summary
);

    localparam int CNT_W = $clog2(MAX_REPORT_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REPORT_BYTES);

    typedef enum logic [1:0] {
        PH_LENGTH = 2'd0,
        PH_TYPE   = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [7:0]              left_reg, left_next;
    bleuuid_pkg::list_src_t  kind_reg, kind_next;
    logic [7:0]              low_reg, low_next;
    logic                    half_reg, half_next;
    logic                    seen_more_reg, seen_more_next;
    logic                    seen_cmpl_reg, seen_cmpl_next;
    logic [2:0]              mm_reg, mm_next;
    logic [2:0]              mc_reg, mc_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    logic [7:0]              left_dec;
    logic [2:0]              hit;

    always_comb
    begin
        phase_next     = phase_reg;
        left_next      = left_reg;
        kind_next      = kind_reg;
        low_next       = low_reg;
        half_next      = half_reg;
        seen_more_next = seen_more_reg;
        seen_cmpl_next = seen_cmpl_reg;
        mm_next        = mm_reg;
        mc_next        = mc_reg;
        cnt_next       = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + CNT_W'(1);
        left_dec       = (left_reg != 8'd0) ? left_reg - 8'd1 : left_reg;
        hit            = bleuuid_pkg::compare_targets({data_byte, low_reg}, targets);

        if (cnt_reg < CNT_MAX)
        begin
            unique case (phase_reg)
                PH_LENGTH:
                begin
                    if (data_byte != 8'd0)
                    begin
                        left_next  = data_byte - 8'd1;
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    kind_next = bleuuid_pkg::SRC_NONE;
                    if (data_byte == bleuuid_pkg::AD_TYPE_UUID16_MORE && !seen_more_reg)
                    begin
                        kind_next      = bleuuid_pkg::SRC_MORE;
                        seen_more_next = 1'b1;
                    end
                    else if (data_byte == bleuuid_pkg::AD_TYPE_UUID16_COMPLETE
                             && !seen_cmpl_reg)
                    begin
                        kind_next      = bleuuid_pkg::SRC_COMPLETE;
                        seen_cmpl_next = 1'b1;
                    end
                    half_next  = 1'b0;
                    phase_next = (left_reg == 8'd0) ? PH_LENGTH : PH_DATA;
                end
                PH_DATA:
                begin
                    if (kind_reg != bleuuid_pkg::SRC_NONE)
                    begin
                        if (!half_reg)
                        begin
                            low_next  = data_byte;
                            half_next = 1'b1;
                        end
                        else
                        begin
                            if (kind_reg == bleuuid_pkg::SRC_MORE)
                                mm_next = mm_reg | hit;
                            else
                                mc_next = mc_reg | hit;
                            half_next = 1'b0;
                        end
                    end
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        phase_next = PH_LENGTH;
                        kind_next  = bleuuid_pkg::SRC_NONE;
                        half_next  = 1'b0;
                    end
                end
                default:
                begin
                    phase_next = PH_LENGTH;
                end
            endcase
        end
    end

    // Summary reflects the state after this byte
    always_comb
    begin
        if (seen_more_next)
        begin
            summary.src   = bleuuid_pkg::SRC_MORE;
            summary.match = mm_next;
        end
        else if (seen_cmpl_next)
        begin
            summary.src   = bleuuid_pkg::SRC_COMPLETE;
            summary.match = mc_next;
        end
        else
        begin
            summary.src   = bleuuid_pkg::SRC_NONE;
            summary.match = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LENGTH;
            left_reg      <= 8'd0;
            kind_reg      <= bleuuid_pkg::SRC_NONE;
            low_reg       <= 8'd0;
            half_reg      <= 1'b0;
            seen_more_reg <= 1'b0;
            seen_cmpl_reg <= 1'b0;
            mm_reg        <= 3'd0;
            mc_reg        <= 3'd0;
            cnt_reg       <= '0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                phase_reg     <= PH_LENGTH;
                left_reg      <= 8'd0;
                kind_reg      <= bleuuid_pkg::SRC_NONE;
                low_reg       <= 8'd0;
                half_reg      <= 1'b0;
                seen_more_reg <= 1'b0;
                seen_cmpl_reg <= 1'b0;
                mm_reg        <= 3'd0;
                mc_reg        <= 3'd0;
                cnt_reg       <= '0;
            end
            else
            begin
                phase_reg     <= phase_next;
                left_reg      <= left_next;
                kind_reg      <= kind_next;
                low_reg       <= low_next;
                half_reg      <= half_next;
                seen_more_reg <= seen_more_next;
                seen_cmpl_reg <= seen_cmpl_next;
                mm_reg        <= mm_next;
                mc_reg        <= mc_next;
                cnt_reg       <= cnt_next;
            end
        end
    end

endmodule

// ----- hdl/ble_adv_uuid16_matcher.sv -----
// Top level: BLE advertising 16-bit service UUID matcher.
`timescale 1ns / 1ps
//
// item:   one advertising-report byte per word (data_byte, last_byte,
//         search_mask). search_mask is only looked at with last_byte.
// result: one word per report, issued for the word that carries last_byte:
//         report_match, list_source, found_mask (sticky), connect_mask.
// cfg:    register writes (index 0..2 = target UUID a/b/c), always ready;
//         other indexes are dropped. Write only while idle.
// Latency: the result is valid the cycle after its last byte is taken.
// Throughput: one byte per cycle unless a result stalls; parse state updates
//   in the same cycle the byte is taken; one output register holds results.
// Stall: while a result waits unaccepted, item.ready stays high only if
//   result.ready is high in that cycle, so nothing is dropped.
// Reset: targets return to 0x1814/0x180D/0x1816, found flags and the parse
//   state clear, the output register is empty.
//
module ble_adv_uuid16_matcher #(
    parameter int MAX_REPORT_BYTES = 31
) (
    input  logic           clk,
    input  logic           rst_n,
    bleuuid_in_if.sink     item,
    bleuuid_out_if.source  result,
    bleuuid_cfg_if.sink    cfg
);

    bleuuid_pkg::target_set_t  targets_reg;
    bleuuid_pkg::report_sum_t  summary;

    logic        out_valid_reg;
    logic [2:0]  match_reg;
    logic [1:0]  src_reg;
    logic [2:0]  found_reg, found_next;
    logic [2:0]  connect_reg;
    logic        take;

    assign cfg.ready  = 1'b1;
    assign item.ready = !out_valid_reg || result.ready;
    assign take       = item.valid && item.ready;

    assign found_next = found_reg | (summary.match & item.search_mask);

    bleuuid_parser #(
        .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (take),
        .data_byte (item.data_byte),
        .last_byte (item.last_byte),
        .targets   (targets_reg),
        .summary   (summary)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            targets_reg.a <= bleuuid_pkg::TARGET_A_RESET;
            targets_reg.b <= bleuuid_pkg::TARGET_B_RESET;
            targets_reg.c <= bleuuid_pkg::TARGET_C_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                bleuuid_pkg::REG_TARGET_A: targets_reg.a <= cfg.wdata;
                bleuuid_pkg::REG_TARGET_B: targets_reg.b <= cfg.wdata;
                bleuuid_pkg::REG_TARGET_C: targets_reg.c <= cfg.wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            found_reg     <= 3'd0;
        end
        else
        begin
            if (take && item.last_byte)
            begin
                out_valid_reg <= 1'b1;
                found_reg     <= found_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && item.last_byte)
        begin
            match_reg   <= summary.match;
            src_reg     <= summary.src;
            connect_reg <= found_next & item.search_mask;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.report_match = match_reg;
    assign result.list_source  = src_reg;
    assign result.found_mask   = found_reg;
    assign result.connect_mask = connect_reg;

endmodule

// ----- tb/ble_adv_uuid16_matcher_tb.sv -----
// Self-checking testbench for the BLE advertising UUID16 matcher.
`timescale 1ns / 1ps

module ble_adv_uuid16_matcher_tb;

    localparam int REPORT_LIMIT   = 31;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 160;
    localparam logic [1:0] REG_IDX_SPARE = 2'd3;

    typedef enum logic [1:0] {AWAIT_LEN, AWAIT_TYPE, IN_DATA} parse_step_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic [2:0] search;
    } adv_word_t;

    typedef struct {
        logic [2:0]             match;
        bleuuid_pkg::list_src_t src;
        logic [2:0]             found;
        logic [2:0]             connect;
    } report_out_t;

    typedef struct {
        logic [1:0]  idx;
        logic [15:0] val;
    } reg_write_t;

    typedef logic [7:0] adv_bytes_t[$];

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bleuuid_in_if  in_ch();
    bleuuid_out_if out_ch();
    bleuuid_cfg_if cfg_ch();

    ble_adv_uuid16_matcher #(.MAX_REPORT_BYTES(REPORT_LIMIT)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch),
        .result (out_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    adv_word_t   pending_q[$];
    report_out_t expect_q[$];
    reg_write_t  cfg_q[$];
    adv_word_t   on_bus;
    reg_write_t  cfg_on_bus;

    // target registers as the block should hold them
    logic [15:0] tgt_a = bleuuid_pkg::TARGET_A_RESET;
    logic [15:0] tgt_b = bleuuid_pkg::TARGET_B_RESET;
    logic [15:0] tgt_c = bleuuid_pkg::TARGET_C_RESET;

    // parser state
    parse_step_t            p_step      = AWAIT_LEN;
    logic [7:0]             p_left      = '0;
    bleuuid_pkg::list_src_t p_kind      = bleuuid_pkg::SRC_NONE;
    logic [7:0]             p_low       = '0;
    logic                   p_half      = 1'b0;
    logic                   p_seen_more = 1'b0;
    logic                   p_seen_comp = 1'b0;
    logic [2:0]             p_hit_more  = '0;
    logic [2:0]             p_hit_comp  = '0;
    int                     p_count     = 0;
    logic [2:0]             sticky_found = '0;

    int n_errors = 0;
    int n_pushed = 0;
    int n_words = 0;
    int n_results = 0;
    int n_writes = 0;
    int n_writes_queued = 0;
    int n_overlong = 0;
    int src_seen[3] = '{0, 0, 0};
    int in_wait = 0;
    int in_calm = 0;
    int out_wait = 0;
    int out_calm = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stall_cycles = 0;

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    task automatic note_error(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
        n_errors++;
    endtask

    // advance the parser by one accepted word; queue a result on the last byte
    task automatic track_word(input adv_word_t w);
        logic [15:0]            uuid;
        logic [2:0]             hit;
        bleuuid_pkg::list_src_t src;
        if (p_count < REPORT_LIMIT)
        begin
            case (p_step)
                AWAIT_LEN:
                begin
                    if (w.data != 8'd0)
                    begin
                        p_left = w.data - 8'd1;
                        p_step = AWAIT_TYPE;
                    end
                end
                AWAIT_TYPE:
                begin
                    p_kind = bleuuid_pkg::SRC_NONE;
                    if (w.data == bleuuid_pkg::AD_TYPE_UUID16_MORE && !p_seen_more)
                    begin
                        p_kind = bleuuid_pkg::SRC_MORE;
                        p_seen_more = 1'b1;
                    end
                    else if (w.data == bleuuid_pkg::AD_TYPE_UUID16_COMPLETE && !p_seen_comp)
                    begin
                        p_kind = bleuuid_pkg::SRC_COMPLETE;
                        p_seen_comp = 1'b1;
                    end
                    p_half = 1'b0;
                    p_step = (p_left == 8'd0) ? AWAIT_LEN : IN_DATA;
                end
                default:
                begin
                    if (p_kind != bleuuid_pkg::SRC_NONE)
                    begin
                        if (!p_half)
                        begin
                            p_low = w.data;
                            p_half = 1'b1;
                        end
                        else
                        begin
                            uuid = {w.data, p_low};
                            hit = {uuid == tgt_c, uuid == tgt_b, uuid == tgt_a};
                            if (p_kind == bleuuid_pkg::SRC_MORE)
                                p_hit_more |= hit;
                            else
                                p_hit_comp |= hit;
                            p_half = 1'b0;
                        end
                    end
                    if (p_left > 8'd0)
                        p_left--;
                    if (p_left == 8'd0)
                    begin
                        p_step = AWAIT_LEN;
                        p_kind = bleuuid_pkg::SRC_NONE;
                        p_half = 1'b0;
                    end
                end
            endcase
        end
        if (p_count < 255)
            p_count++;
        if (w.last)
        begin
            if (p_seen_more)
            begin
                src = bleuuid_pkg::SRC_MORE;
                hit = p_hit_more;
            end
            else if (p_seen_comp)
            begin
                src = bleuuid_pkg::SRC_COMPLETE;
                hit = p_hit_comp;
            end
            else
            begin
                src = bleuuid_pkg::SRC_NONE;
                hit = '0;
            end
            sticky_found |= hit & w.search;
            expect_q.push_back('{hit, src, sticky_found, sticky_found & w.search});
            src_seen[int'(src)]++;
            if (p_count > REPORT_LIMIT)
                n_overlong++;
            p_step = AWAIT_LEN;
            p_left = '0;
            p_kind = bleuuid_pkg::SRC_NONE;
            p_low = '0;
            p_half = 1'b0;
            p_seen_more = 1'b0;
            p_seen_comp = 1'b0;
            p_hit_more = '0;
            p_hit_comp = '0;
            p_count = 0;
        end
    endtask

    // byte sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data_byte <= '0;
            in_ch.last_byte <= 1'b0;
            in_ch.search_mask <= '0;
            in_wait = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                track_word(on_bus);
                n_words++;
                in_wait = draw_wait(in_calm);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (in_wait > 0 || pending_q.size() == 0)
                begin
                    if (in_wait > 0)
                        in_wait--;
                    in_ch.valid <= 1'b0;
                end
                else
                begin
                    on_bus = pending_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.data_byte <= on_bus.data;
                    in_ch.last_byte <= on_bus.last;
                    in_ch.search_mask <= on_bus.search;
                end
            end
        end
    end

    // result receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        report_out_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_wait = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expect_q.size() == 0)
                    note_error("result word with none pending", int'(out_ch.report_match), -1);
                else
                begin
                    want = expect_q.pop_front();
                    if (out_ch.report_match !== want.match)
                        note_error("report_match", int'(out_ch.report_match),
                                   int'(want.match));
                    if (out_ch.list_source !== want.src)
                        note_error("list_source", int'(out_ch.list_source), int'(want.src));
                    if (out_ch.found_mask !== want.found)
                        note_error("found_mask", int'(out_ch.found_mask), int'(want.found));
                    if (out_ch.connect_mask !== want.connect)
                        note_error("connect_mask", int'(out_ch.connect_mask),
                                   int'(want.connect));
                end
                n_results++;
                out_wait = draw_wait(out_calm);
                // long stall while the sender still has plenty queued
                if (!hold_done && n_results >= 30 && pending_q.size() >= 40)
                begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (out_wait > 0)
            begin
                out_wait--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // register writer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.reg_index <= '0;
            cfg_ch.wdata <= '0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_on_bus.idx)
                    bleuuid_pkg::REG_TARGET_A: tgt_a = cfg_on_bus.val;
                    bleuuid_pkg::REG_TARGET_B: tgt_b = cfg_on_bus.val;
                    bleuuid_pkg::REG_TARGET_C: tgt_c = cfg_on_bus.val;
                    default: ;
                endcase
                n_writes++;
            end
            if (!cfg_ch.valid || cfg_ch.ready)
            begin
                if (cfg_q.size() != 0)
                begin
                    cfg_on_bus = cfg_q.pop_front();
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.reg_index <= cfg_on_bus.idx;
                    cfg_ch.wdata <= cfg_on_bus.val;
                end
                else
                    cfg_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", stall_cycles);
            $display("ble_adv_uuid16_matcher_tb: done, errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic add_report(input adv_bytes_t bytes, input logic [2:0] srch);
        adv_word_t w;
        for (int i = 0; i < bytes.size(); i++)
        begin
            w.data = bytes[i];
            w.last = (i == bytes.size() - 1);
            w.search = w.last ? srch : 3'($urandom_range(0, 7));
            pending_q.push_back(w);
            n_pushed++;
        end
    endtask

    task automatic settle();
        while (n_words != n_pushed || expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_targets(input logic [15:0] a, input logic [15:0] b,
                               input logic [15:0] c);
        cfg_q.push_back('{bleuuid_pkg::REG_TARGET_A, a});
        cfg_q.push_back('{bleuuid_pkg::REG_TARGET_B, b});
        cfg_q.push_back('{bleuuid_pkg::REG_TARGET_C, c});
        n_writes_queued += 3;
        while (n_writes != n_writes_queued)
            @(posedge clk);
    endtask

    // random reports: mostly well-formed structures, some noise and truncation
    task automatic run_phase(input int budget);
        adv_bytes_t  rep;
        logic [15:0] u;
        int queued;
        int kind;
        int n;
        int sel;
        int pairs;
        int odd;
        int dlen;
        int cut;
        queued = 0;
        while (queued < budget)
        begin
            rep = {};
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                n = $urandom_range(1, 12);
                repeat (n) rep.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                n = (kind == 1) ? $urandom_range(5, 9) : $urandom_range(1, 4);
                repeat (n)
                begin
                    sel = $urandom_range(0, 9);
                    if (sel == 0)
                        rep.push_back(8'h00);
                    else if (sel <= 6)
                    begin
                        pairs = $urandom_range(0, 4);
                        odd = ($urandom_range(0, 4) == 0);
                        rep.push_back(8'(1 + 2 * pairs + odd));
                        rep.push_back(sel <= 3 ? bleuuid_pkg::AD_TYPE_UUID16_COMPLETE
                                               : bleuuid_pkg::AD_TYPE_UUID16_MORE);
                        repeat (pairs)
                        begin
                            case ($urandom_range(0, 4))
                                0: u = tgt_a;
                                1: u = tgt_b;
                                2: u = tgt_c;
                                default: u = 16'($urandom_range(0, 65535));
                            endcase
                            rep.push_back(u[7:0]);
                            rep.push_back(u[15:8]);
                        end
                        if (odd)
                            rep.push_back(8'($urandom_range(0, 255)));
                    end
                    else
                    begin
                        dlen = $urandom_range(0, 5);
                        rep.push_back(8'(dlen + 1));
                        rep.push_back(8'($urandom_range(0, 255)));
                        repeat (dlen) rep.push_back(8'($urandom_range(0, 255)));
                    end
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    cut = $urandom_range(1, rep.size());
                    while (rep.size() > cut)
                        void'(rep.pop_back());
                end
            end
            add_report(rep, 3'($urandom_range(0, 7)));
            queued += rep.size();
        end
        settle();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // padding, more-available list with two targets, search drops one
        add_report({8'h00, 8'h05, 8'h02, 8'h0D, 8'h18, 8'h14, 8'h18}, 3'd6);
        // complete list with odd tail, then a truncated more-available list
        add_report({8'h04, 8'h03, 8'h16, 8'h18, 8'hFF, 8'h03, 8'h02, 8'h16}, 3'd0);
        // lone length byte ends the report
        add_report({8'hFF}, 3'd7);
        // repeated complete list ignored, trailing padding
        add_report({8'h03, 8'h03, 8'h16, 8'h18, 8'h03, 8'h03, 8'h14, 8'h18, 8'h00},
                   3'd5);
        settle();
        run_phase(100);

        set_targets(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)));
        run_phase(100);

        cfg_q.push_back('{REG_IDX_SPARE, 16'hA5C3});
        n_writes_queued++;
        set_targets(16'h0000, 16'hFFFF, 16'h0000);
        run_phase(100);

        set_targets(16'hFFFF, 16'h0000, 16'hFFFF);
        run_phase(100);

        set_targets(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)));
        run_phase(100);

        set_targets(bleuuid_pkg::TARGET_A_RESET, bleuuid_pkg::TARGET_B_RESET,
                    bleuuid_pkg::TARGET_C_RESET);
        run_phase(100);

        $display("covered %0d bytes, %0d reports: %0d more list, %0d complete, %0d none",
                 n_words, n_results, src_seen[1], src_seen[2], src_seen[0]);
        $display("%0d overlong reports, %0d register writes, long result stall %s",
                 n_overlong, n_writes, hold_done ? "applied" : "not reached");
        if (n_errors == 0)
            $display("ble_adv_uuid16_matcher_tb: done, clean");
        else
            $display("ble_adv_uuid16_matcher_tb: done, errors");
        $finish;
    end

endmodule
